>>> src/sti_pkg.sv
// shared types and constants for the symbol table insert block
// no dependencies; used by sti_cell and symbol_table_insert
package sti_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int KEY_CHARS_DEF   = 8;
  localparam int KEY_BITS_MAX    = 64;
  localparam int NAME_LEN_W      = 8;
  localparam int VALUE_W         = 16;
  localparam int SLOT_OUT_W      = 8;

  typedef enum logic [1:0] {
    STATUS_INSERTED  = 2'd0,
    STATUS_REDEFINED = 2'd1,
    STATUS_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic [KEY_BITS_MAX-1:0] symbol_key;
    logic [NAME_LEN_W-1:0]   name_length;
    logic [VALUE_W-1:0]      entry_value;
  } request_t;

  typedef struct packed {
    status_t                 insert_status;
    logic                    long_name_warning;
    logic [SLOT_OUT_W-1:0]   slot_index;
  } result_t;

  // control flags that travel with a query down the cell chain
  typedef struct packed {
    logic valid;
    logic hit;
    logic wrote;
  } tok_flags_t;

endpackage

>>> src/sti_cell.sv
// one slot of the symbol table: stored key and value plus one query stage
// depends on sti_pkg
module sti_cell #(
  parameter int KEY_W = 64,
  parameter int CNT_W = 9,
  parameter int IDX_W = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  sti_pkg::tok_flags_t       in_flags,
  input  logic [KEY_W-1:0]          in_key,
  input  logic [sti_pkg::VALUE_W-1:0] in_value,
  input  logic [CNT_W-1:0]          in_left,
  input  logic [IDX_W-1:0]          in_pos,
  input  logic [IDX_W-1:0]          in_slot,
  output sti_pkg::tok_flags_t       out_flags,
  output logic [KEY_W-1:0]          out_key,
  output logic [sti_pkg::VALUE_W-1:0] out_value,
  output logic [CNT_W-1:0]          out_left,
  output logic [IDX_W-1:0]          out_pos,
  output logic [IDX_W-1:0]          out_slot
);

  logic [KEY_W-1:0]            key_q;
  logic [sti_pkg::VALUE_W-1:0] value_q;
  logic                        filled;
  logic                        match;
  logic                        wr_here;
  sti_pkg::tok_flags_t         flags_next;

  // this slot is filled when the query still has filled slots ahead
  assign filled  = (in_left != '0);
  assign match   = in_flags.valid && filled && !in_flags.hit && (key_q == in_key);
  assign wr_here = in_flags.valid && !filled && !in_flags.hit && !in_flags.wrote;

  always_comb begin
    flags_next       = in_flags;
    flags_next.hit   = in_flags.hit || match;
    flags_next.wrote = in_flags.wrote || wr_here;
  end

  // stored slot contents, undefined until written
  always_ff @(posedge clk) begin
    if (wr_here) begin
      key_q   <= in_key;
      value_q <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_flags <= '0;
    end else begin
      out_flags <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    out_key   <= in_key;
    out_value <= in_value;
    out_left  <= filled ? in_left - CNT_W'(1) : in_left;
    out_pos   <= in_pos + IDX_W'(1);
    out_slot  <= match ? in_pos : in_slot;
  end

endmodule

>>> src/symbol_table_insert.sv
// symbol table insert with duplicate check: a query walks a row of slot cells
// done and the result beat are registered together as the query leaves the tail of the chain
// a new insert is taken only once the previous query has left the tail of the cell chain
// busy is high from the accepting edge until the edge that raises done
// reset clears the entry count and the chain; stored keys stay unknown until written
// depends on sti_pkg and sti_cell
module symbol_table_insert #(
  parameter int TABLE_DEPTH = sti_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_CHARS   = sti_pkg::KEY_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  sti_pkg::request_t request,
  output logic              busy,
  output logic              done,
  output sti_pkg::result_t  result
);

  localparam int KEY_W = 8 * KEY_CHARS;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // chain taps: index 0 is the injected query, index TABLE_DEPTH the tail
  sti_pkg::tok_flags_t         c_flags [0:TABLE_DEPTH];
  logic [KEY_W-1:0]            c_key   [0:TABLE_DEPTH];
  logic [sti_pkg::VALUE_W-1:0] c_value [0:TABLE_DEPTH];
  logic [CNT_W-1:0]            c_left  [0:TABLE_DEPTH];
  logic [IDX_W-1:0]            c_pos   [0:TABLE_DEPTH];
  logic [IDX_W-1:0]            c_slot  [0:TABLE_DEPTH];

  logic             accept;
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] entry_count_next;
  logic             warn;
  logic             busy_next;
  logic             table_full;
  sti_pkg::result_t result_next;

  assign accept     = start && !busy;
  assign table_full = (entry_count == CNT_W'(TABLE_DEPTH));

  // inject the cut key; left counts the filled slots the query still has to pass
  always_comb begin
    c_flags[0]       = '0;
    c_flags[0].valid = accept;
    c_key[0]         = request.symbol_key[KEY_W-1:0];
    c_value[0]       = request.entry_value;
    c_left[0]        = entry_count;
    c_pos[0]         = '0;
    c_slot[0]        = '0;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    sti_cell #(
      .KEY_W (KEY_W),
      .CNT_W (CNT_W),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_flags  (c_flags[i]),
      .in_key    (c_key[i]),
      .in_value  (c_value[i]),
      .in_left   (c_left[i]),
      .in_pos    (c_pos[i]),
      .in_slot   (c_slot[i]),
      .out_flags (c_flags[i+1]),
      .out_key   (c_key[i+1]),
      .out_value (c_value[i+1]),
      .out_left  (c_left[i+1]),
      .out_pos   (c_pos[i+1]),
      .out_slot  (c_slot[i+1])
    );
  end

  // warning depends only on the original name length
  always_ff @(posedge clk) begin
    if (accept) begin
      warn <= (request.name_length > sti_pkg::NAME_LEN_W'(KEY_CHARS));
    end
  end

  // result from the query as it leaves the tail of the chain
  always_comb begin
    result_next                   = '0;
    result_next.long_name_warning = warn;
    priority if (c_flags[TABLE_DEPTH].hit) begin
      result_next.insert_status = sti_pkg::STATUS_REDEFINED;
      result_next.slot_index    = sti_pkg::SLOT_OUT_W'(c_slot[TABLE_DEPTH]);
    end else if (table_full) begin
      result_next.insert_status = sti_pkg::STATUS_FULL;
    end else begin
      result_next.insert_status = sti_pkg::STATUS_INSERTED;
      result_next.slot_index    = sti_pkg::SLOT_OUT_W'(entry_count);
    end
  end

  // count rises when the tail reports a fresh insert
  always_comb begin
    entry_count_next = entry_count;
    if (c_flags[TABLE_DEPTH].valid && !c_flags[TABLE_DEPTH].hit && !table_full) begin
      entry_count_next = entry_count + CNT_W'(1);
    end
  end

  always_comb begin
    busy_next = busy;
    if (accept) begin
      busy_next = 1'b1;
    end else if (c_flags[TABLE_DEPTH].valid) begin
      busy_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      busy        <= 1'b0;
      done        <= 1'b0;
    end else begin
      entry_count <= entry_count_next;
      busy        <= busy_next;
      done        <= c_flags[TABLE_DEPTH].valid;
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (c_flags[TABLE_DEPTH].valid) begin
      result <= result_next;
    end
  end

  // the count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // a result beat only closes a busy period
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("done without a pending insert");

  // a query at the tail wrote its slot unless it hit or the table was full
  a_tail_wrote: assert property (@(posedge clk) disable iff (rst)
    c_flags[TABLE_DEPTH].valid && !c_flags[TABLE_DEPTH].hit && !table_full
      |-> c_flags[TABLE_DEPTH].wrote)
    else $error("insert reached tail without writing");

  // the count moves only with a reported insert
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (entry_count != $past(entry_count)) && !$past(rst)
      |-> done && (result.insert_status == sti_pkg::STATUS_INSERTED))
    else $error("count changed without an insert");

endmodule

>>> sim/symbol_table_insert_test.sv
// self-checking testbench for the symbol table insert block
// depends on sti_pkg and symbol_table_insert (with sti_cell below it)
`timescale 1ns / 100ps

module symbol_table_insert_test;

  localparam int DEPTH = sti_pkg::TABLE_DEPTH_DEF;
  localparam int CHARS = sti_pkg::KEY_CHARS_DEF;
  localparam int ITEMS = 1700;
  // worst beat: a full drain, the longest idle burst, then the walk itself
  localparam int BEAT_CYCLES = 2 * (DEPTH + 1) + 13 + 4;
  localparam int RUN_LIMIT = 3 * ITEMS * BEAT_CYCLES + 10 * DEPTH + 1000;
  // no idle bursts over this many final beats
  localparam int QUIET_TAIL = 200;

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  sti_pkg::request_t request;
  logic              busy;
  logic              done;
  sti_pkg::result_t  result;

  // one directed beat; literal marks rows whose outcome is typed in by hand
  typedef struct {
    sti_pkg::request_t req;
    bit                literal;
    sti_pkg::result_t  want;
  } stim_row_t;

  stim_row_t directed_rows[$];

  // shadow copy of the table contents
  logic [63:0] shadow_keys [DEPTH];
  logic [15:0] shadow_values [DEPTH];
  int          shadow_count;

  sti_pkg::result_t pending_results[$];
  int               mismatches;
  int               results_seen;
  int               cycle_count;

  always #5 clk = ~clk;

  symbol_table_insert #(
    .TABLE_DEPTH(DEPTH),
    .KEY_CHARS  (CHARS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .request(request),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // drop every character at and above the key length
  function automatic logic [63:0] cut_key(input logic [63:0] key);
    logic [63:0] k;
    k = key;
    for (int b = CHARS; b < 8; b++) k[8*b +: 8] = 8'h00;
    return k;
  endfunction

  // duplicate search over filled slots, then full check, then append
  function automatic sti_pkg::result_t predict_insert(input sti_pkg::request_t req);
    logic [63:0]      key;
    sti_pkg::result_t res;
    int               hit;
    key = cut_key(req.symbol_key);
    hit = -1;
    res.long_name_warning = (req.name_length > CHARS);
    res.insert_status = sti_pkg::STATUS_FULL;
    res.slot_index = '0;
    for (int i = 0; i < shadow_count; i++) begin
      if (hit < 0 && shadow_keys[i] == key) hit = i;
    end
    if (hit >= 0) begin
      // lowest matching slot wins, even in a full table
      res.insert_status = sti_pkg::STATUS_REDEFINED;
      res.slot_index = hit[sti_pkg::SLOT_OUT_W-1:0];
    end else if (shadow_count < DEPTH) begin
      shadow_keys[shadow_count] = key;
      shadow_values[shadow_count] = req.entry_value;
      res.insert_status = sti_pkg::STATUS_INSERTED;
      res.slot_index = shadow_count[sti_pkg::SLOT_OUT_W-1:0];
      shadow_count++;
    end
    return res;
  endfunction

  // random name: either 64 random bits or a zero-padded name of 0..8 chars
  function automatic logic [63:0] fresh_key();
    logic [63:0] k;
    int          chars;
    k = {$urandom(), $urandom()};
    if ($urandom_range(0, 1) == 1) begin
      chars = $urandom_range(0, 8);
      for (int b = chars; b < 8; b++) k[8*b +: 8] = 8'h00;
    end
    return k;
  endfunction

  task automatic add_row(input logic [63:0] key, input logic [7:0] len,
                         input logic [15:0] val, input bit literal,
                         input sti_pkg::status_t st, input logic warn,
                         input logic [7:0] slot);
    stim_row_t row;
    row.req.symbol_key = key;
    row.req.name_length = len;
    row.req.entry_value = val;
    row.literal = literal;
    row.want.insert_status = st;
    row.want.long_name_warning = warn;
    row.want.slot_index = slot;
    directed_rows.push_back(row);
  endtask

  task automatic note_mismatch(input string what, input sti_pkg::result_t want,
                               input sti_pkg::result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("beat %0d %s: expected status %0d warn %0b slot %0d, %s %0d warn %0b slot %0d",
               results_seen, what, want.insert_status, want.long_name_warning,
               want.slot_index, "got status", got.insert_status,
               got.long_name_warning, got.slot_index);
    end
  endtask

  // called at a falling edge; returns at the falling edge after the accepting beat
  task automatic send_beat(input sti_pkg::request_t req, input bit literal,
                           input sti_pkg::result_t want);
    sti_pkg::result_t predicted;
    start <= 1'b1;
    request <= req;
    // busy only moves on rising edges, so its value here holds for the next edge
    while (busy) @(negedge clk);
    @(posedge clk);
    predicted = predict_insert(req);
    pending_results.push_back(literal ? want : predicted);
    @(negedge clk);
  endtask

  // idle burst on the sender side; with drain it first lets the block empty out,
  // so the burst lands in the idle phase instead of inside a walk
  task automatic idle_burst(input bit drain, input int cycles);
    start <= 1'b0;
    if (drain) begin
      while (pending_results.size() != 0) @(negedge clk);
    end
    repeat (cycles) @(negedge clk);
  endtask

  // result side: done is a one-cycle strobe, taken at the edge that ends it
  always @(posedge clk) begin
    sti_pkg::result_t want;
    if (!rst && done) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        want = '0;
        note_mismatch("result with nothing pending", want, result);
      end else begin
        want = pending_results.pop_front();
        if (result.insert_status !== want.insert_status ||
            result.long_name_warning !== want.long_name_warning ||
            result.slot_index !== want.slot_index) begin
          note_mismatch("mismatch", want, result);
        end
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("symbol_table_insert_test: errors");
    $finish;
  end

  initial begin
    sti_pkg::request_t req;
    int                random_items;
    int                fill;
    sti_pkg::result_t  no_want;

    rst = 1'b1;
    start = 1'b0;
    request = '0;
    shadow_count = 0;
    mismatches = 0;
    results_seen = 0;
    no_want = '0;

    // directed rows: empty key, all-ones key, length at and past the key size,
    // duplicates with and without the warning, value extremes
    add_row(64'h0, 8'd0, 16'h0000, 1'b1, sti_pkg::STATUS_INSERTED, 1'b0, 8'd0);
    add_row({64{1'b1}}, 8'd8, 16'hFFFF, 1'b1, sti_pkg::STATUS_INSERTED, 1'b0, 8'd1);
    add_row(64'h0, 8'd9, 16'h1234, 1'b1, sti_pkg::STATUS_REDEFINED, 1'b1, 8'd0);
    add_row({64{1'b1}}, 8'd255, 16'h0000, 1'b1, sti_pkg::STATUS_REDEFINED, 1'b1, 8'd1);
    add_row(64'h61, 8'd1, 16'h0001, 1'b1, sti_pkg::STATUS_INSERTED, 1'b0, 8'd2);
    add_row(64'h6261, 8'd12, 16'h8000, 1'b1, sti_pkg::STATUS_INSERTED, 1'b1, 8'd3);
    add_row(64'h61, 8'd1, 16'hBEEF, 1'b1, sti_pkg::STATUS_REDEFINED, 1'b0, 8'd2);
    add_row(64'h8000_0000_0000_0000, 8'd8, 16'h7FFF, 1'b1, sti_pkg::STATUS_INSERTED,
            1'b0, 8'd4);
    add_row(64'h1, 8'd0, 16'h0002, 1'b1, sti_pkg::STATUS_INSERTED, 1'b0, 8'd5);
    // remaining rows go through the predictor
    add_row(64'h4C4F_4F50_5F45_4E44, 8'd8, 16'h00FF, 1'b0, sti_pkg::STATUS_INSERTED,
            1'b0, 8'd0);
    add_row(64'h5555_5555_5555_5555, 8'hAA, 16'h5555, 1'b0, sti_pkg::STATUS_INSERTED,
            1'b0, 8'd0);
    add_row(64'hAAAA_AAAA_AAAA_AAAA, 8'h55, 16'hAAAA, 1'b0, sti_pkg::STATUS_INSERTED,
            1'b0, 8'd0);
    add_row(64'h5555_5555_5555_5555, 8'd3, 16'h0F0F, 1'b0, sti_pkg::STATUS_INSERTED,
            1'b0, 8'd0);
    add_row(64'h0123_4567_89AB_CDEF, 8'd7, 16'hF0F0, 1'b0, sti_pkg::STATUS_INSERTED,
            1'b0, 8'd0);
    add_row(64'h8000_0000_0000_0000, 8'd0, 16'h0100, 1'b0, sti_pkg::STATUS_INSERTED,
            1'b0, 8'd0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].req, directed_rows[i].literal, directed_rows[i].want);
    end

    // random part: fill the table with mostly fresh names and some repeats,
    // then keep hammering the full table with repeats and newcomers
    random_items = ITEMS - directed_rows.size();
    for (int n = 0; n < random_items; n++) begin
      if (n == random_items / 2) begin
        // hold off until every outstanding result is back
        idle_burst(1'b1, 1);
      end else if (n < random_items - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
        idle_burst($urandom_range(0, 1) == 1, $urandom_range(1, 13));
      end
      fill = shadow_count;
      if (fill != 0 && $urandom_range(0, 99) < (fill >= DEPTH ? 55 : 25)) begin
        req.symbol_key = shadow_keys[$urandom_range(0, fill - 1)];
      end else begin
        req.symbol_key = fresh_key();
      end
      if ($urandom_range(0, 3) == 0) begin
        req.name_length = 8'($urandom_range(0, 255));
      end else begin
        req.name_length = 8'($urandom_range(0, CHARS));
      end
      req.entry_value = 16'($urandom());
      send_beat(req, 1'b0, no_want);
    end

    // drain, then one more walk length to catch a stray strobe
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DEPTH + 8) @(negedge clk);

    if (mismatches == 0) begin
      $display("symbol_table_insert_test: clean");
    end else begin
      $display("symbol_table_insert_test: errors");
    end
    $finish;
  end

endmodule

>>> files.f
src/sti_pkg.sv
src/sti_cell.sv
src/symbol_table_insert.sv
sim/symbol_table_insert_test.sv
